>>> rtl/core/protobuf_field_encoder_top_defines.svh
// Assertion macros shared by the protobuf field encoder modules.
`ifndef PROTOBUF_FIELD_ENCODER_TOP_DEFINES_SVH
`define PROTOBUF_FIELD_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define PFE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("protobuf field encoder assertion failed");

// Checks that a condition never holds outside of reset.
`define PFE_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("protobuf field encoder forbidden condition seen");

`else

`define PFE_ASSERT(lbl, clk, rst, prop)
`define PFE_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> rtl/core/pfe_pkg.sv
// Types, codes and helper functions of the protobuf field encoder.
package pfe_pkg;

   // Operation codes of an input transaction.
   typedef enum logic [1:0] {
      OP_VARINT  = 2'd0,
      OP_HEADER  = 2'd1,
      OP_PAYLOAD = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // Status codes reported on every result.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_FIELD = 2'd1,
      ST_NO_ROOM  = 2'd2,
      ST_SEQUENCE = 2'd3
   } status_type;

   // Work kinds handed from the front end to the emitter.
   typedef enum logic [1:0] {
      KIND_SINGLE = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_FIELD  = 2'd2
   } kind_type;

   localparam int unsigned WIRE_VARINT = 0;
   localparam int unsigned WIRE_LEN    = 2;

   // One classified transaction waiting for the emitter.
   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [31:0] key;
      logic [2:0]  key_len;
      logic [63:0] value;
      logic [3:0]  val_len;
      logic [7:0]  payload;
      logic [15:0] committed;
   } cmd_type;

   // Number of LEB128 bytes needed for a 64-bit value.
   function automatic logic [3:0] leb_len(input logic [63:0] v);
      logic [3:0] n;
      n = 4'd1;
      for (int i = 1; i < 10; i++) begin
         if ((v >> (7 * i)) != 64'd0) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/core/pfe_front.sv
// Front end: holds capacity and message state, classifies each transaction.
module pfe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data,
   input  logic             accept,
   input  logic [1:0]       req_op,
   input  logic [31:0]      req_field_number,
   input  logic [63:0]      req_value,
   input  logic [7:0]       req_payload_byte,
   output pfe_pkg::cmd_type cmd
);
   import pfe_pkg::*;

   logic [15:0] capacity_ff, capacity_in;
   logic [15:0] committed_ff, committed_in;
   logic [15:0] pending_ff, pending_in;

   op_type      op;
   logic [31:0] key;
   logic [3:0]  key_len_full;
   logic [3:0]  val_len;
   logic [15:0] avail;
   logic [4:0]  prefix;
   logic [15:0] room_left;
   logic        bad_field;
   logic        no_room;

   // Key, encoded lengths and the room check.
   always_comb begin
      op           = op_type'(req_op);
      key          = {req_field_number[28:0], 3'b000}
                     | ((op == OP_HEADER) ? 32'(WIRE_LEN) : 32'(WIRE_VARINT));
      key_len_full = leb_len({32'd0, key});
      val_len      = leb_len(req_value);
      avail        = (capacity_ff > committed_ff) ? (capacity_ff - committed_ff) : 16'd0;
      prefix       = {2'b00, key_len_full[2:0]} + {1'b0, val_len};
      room_left    = avail - {11'd0, prefix};
      bad_field    = (req_field_number == 32'd0) || (req_field_number[31:29] != 3'd0);
      no_room      = ({11'd0, prefix} > avail)
                     || ((op == OP_HEADER)
                         && ((req_value[63:16] != 48'd0) || (req_value[15:0] > room_left)));
   end

   // Classification and next message state.
   always_comb begin
      committed_in      = committed_ff;
      pending_in        = pending_ff;
      cmd.kind          = KIND_SINGLE;
      cmd.status        = ST_OK;
      cmd.key           = key;
      cmd.key_len       = key_len_full[2:0];
      cmd.value         = req_value;
      cmd.val_len       = val_len;
      cmd.payload       = req_payload_byte;
      unique case (op)
         OP_CLEAR: begin
            committed_in = 16'd0;
            pending_in   = 16'd0;
         end
         OP_PAYLOAD: begin
            if (pending_ff == 16'd0) begin
               cmd.status = ST_SEQUENCE;
            end else begin
               cmd.kind     = KIND_BYTE;
               committed_in = committed_ff + 16'd1;
               pending_in   = pending_ff - 16'd1;
            end
         end
         default: begin
            if (pending_ff != 16'd0) begin
               cmd.status = ST_SEQUENCE;
            end else if (bad_field) begin
               cmd.status = ST_BAD_FIELD;
            end else if (no_room) begin
               cmd.status = ST_NO_ROOM;
            end else begin
               cmd.kind     = KIND_FIELD;
               committed_in = committed_ff + {11'd0, prefix};
               if (op == OP_HEADER) begin
                  pending_in = req_value[15:0];
               end
            end
         end
      endcase
      cmd.committed = committed_in;
   end

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   // Configuration and message state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= 16'hFFFF;
         committed_ff <= 16'd0;
         pending_ff   <= 16'd0;
      end else begin
         capacity_ff <= capacity_in;
         if (accept) begin
            committed_ff <= committed_in;
            pending_ff   <= pending_in;
         end
      end
   end

endmodule

>>> rtl/core/pfe_queue.sv
// Two-entry queue of classified transactions between front end and emitter.
`include "protobuf_field_encoder_top_defines.svh"

module pfe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfe_pkg::cmd_type push_cmd,
   input  logic             pop,
   output pfe_pkg::cmd_type pop_cmd,
   output logic             full,
   output logic             not_empty
);
   import pfe_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PFE_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && full)
   `PFE_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, pop && !not_empty)
   `PFE_ASSERT(a_count_bound, clock, reset, count_ff != 2'd3)

endmodule

>>> rtl/core/pfe_back.sv
// Emitter: turns a classified transaction into result bytes, one per cycle while the result is not stalled.
`include "protobuf_field_encoder_top_defines.svh"

module pfe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  pfe_pkg::cmd_type cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_committed
);
   import pfe_pkg::*;

   // Working copy of the transaction being emitted.
   logic        busy_ff, busy_in;
   kind_type    kind_ff;
   status_type  status_ff;
   logic [31:0] key_ff, key_in;
   logic [2:0]  key_cnt_ff, key_cnt_in;
   logic [63:0] val_ff, val_in;
   logic [3:0]  val_cnt_ff, val_cnt_in;
   logic [7:0]  byte_ff;
   logic [15:0] comm_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        byte_valid_ff;
   logic        last_ff;
   logic [1:0]  status_out_ff;
   logic [15:0] committed_out_ff;

   logic        out_free;
   logic        emit;
   logic        last_c;
   logic [7:0]  byte_c;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;
   assign pop      = !busy_ff && cmd_valid;
   assign last_c   = (kind_ff != KIND_FIELD) || ((key_cnt_ff == 3'd0) && (val_cnt_ff == 4'd1));

   // Byte selection: key bytes first, then value bytes, with continuation bits; or the payload byte.
   always_comb begin
      case (kind_ff)
         KIND_BYTE:  byte_c = byte_ff;
         KIND_FIELD: begin
            if (key_cnt_ff != 3'd0) begin
               byte_c = {key_cnt_ff != 3'd1, key_ff[6:0]};
            end else begin
               byte_c = {val_cnt_ff != 4'd1, val_ff[6:0]};
            end
         end
         default:    byte_c = 8'd0;
      endcase
   end

   // Next working state.
   always_comb begin
      busy_in    = busy_ff;
      key_in     = key_ff;
      key_cnt_in = key_cnt_ff;
      val_in     = val_ff;
      val_cnt_in = val_cnt_ff;
      if (pop) begin
         busy_in    = 1'b1;
         key_in     = cmd.key;
         key_cnt_in = cmd.key_len;
         val_in     = cmd.value;
         val_cnt_in = cmd.val_len;
      end else if (emit) begin
         if (last_c) begin
            busy_in = 1'b0;
         end else if (key_cnt_ff != 3'd0) begin
            key_in     = key_ff >> 7;
            key_cnt_in = key_cnt_ff - 3'd1;
         end else begin
            val_in     = val_ff >> 7;
            val_cnt_in = val_cnt_ff - 4'd1;
         end
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      key_cnt_ff <= key_cnt_in;
      val_ff     <= val_in;
      val_cnt_ff <= val_cnt_in;
      if (pop) begin
         kind_ff   <= cmd.kind;
         status_ff <= cmd.status;
         byte_ff   <= cmd.payload;
         comm_ff   <= cmd.committed;
      end
      if (emit) begin
         out_byte_ff      <= byte_c;
         byte_valid_ff    <= (kind_ff != KIND_SINGLE);
         last_ff          <= last_c;
         status_out_ff    <= status_ff;
         committed_out_ff <= comm_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_out_ff;
   assign rsp_committed  = committed_out_ff;

   `PFE_ASSERT(a_empty_result_is_last, clock, reset,
      (rsp_valid_ff && !byte_valid_ff) |-> last_ff)
   `PFE_ASSERT(a_field_has_bytes_left, clock, reset,
      (busy_ff && kind_ff == KIND_FIELD) |-> (key_cnt_ff != 3'd0 || val_cnt_ff != 4'd0))
   `PFE_ASSERT(a_last_frees_emitter, clock, reset, (emit && last_c) |=> !busy_ff)

endmodule

>>> rtl/core/protobuf_field_encoder_top.sv
// Protobuf field encoder: serializes wire-format fields into a bounded buffer.
//
// Input channel (req_*): one transaction per valid/stall handshake carries an
// op (varint field, length-delimited header, payload byte, clear), a field
// number, a 64-bit value and a payload byte. Result channel (rsp_*): one
// transaction per output byte; a failing or clear transaction gives a single
// result with rsp_byte_valid low. rsp_last marks the final result of a
// transaction. csr_wr_en/csr_wr_data set the buffer capacity; write it only
// while the block is idle.
// A transaction is classified in the cycle it is accepted and waits in a
// two-entry queue; the emitter loads it and then sends one byte per cycle
// while the result is not stalled, and takes the next transaction only after
// the last result of the current one has gone into the result register.
// The front end keeps accepting while the queue has room, also while a result
// waits on rsp_stall; a stalled result holds its value.
// Reset clears the queue, the committed count and the owed payload count and
// sets capacity to 65535.
module protobuf_field_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_field_number,
   input  logic [63:0] req_value,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_committed
);
   import pfe_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    accept;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;

   // A transaction is taken whenever the queue has a free entry.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   pfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .accept           (accept),
      .req_op           (req_op),
      .req_field_number (req_field_number),
      .req_value        (req_value),
      .req_payload_byte (req_payload_byte),
      .cmd              (front_cmd)
   );

   pfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .pop_cmd   (queue_cmd),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   pfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_not_empty),
      .cmd            (queue_cmd),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .rsp_committed  (rsp_committed)
   );

endmodule
